// ===== rtl/core/phf_pkg.sv =====
`default_nettype none
package phf_pkg;

  localparam int PAGE_BYTES      = 512;
  localparam int HEADER_BYTES    = 5;
  localparam int PAGE_MIN        = 16;
  localparam int PAGE_SIZE_RESET = 512;

  localparam int AW     = $clog2(PAGE_BYTES);
  localparam int PW     = $clog2(PAGE_BYTES + 1);
  localparam int WAW    = AW + 2;
  localparam int POS_W  = 33;
  localparam int SIZE_W = 32;
  localparam int CFG_W  = 10;
  localparam int AMT_W  = 10;
  localparam int OFS_W  = 9;

  typedef enum logic [1:0] {
    OP_FORMAT = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_FREE   = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TOO_BIG    = 2'd1,
    ST_NO_FREE    = 2'd2,
    ST_BAD_OFFSET = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_CLR, S_FMT, S_HRD, S_HCAP, S_EVAL,
    S_ADV, S_CHK, S_AWR, S_MWR, S_FCLR, S_RES
  } fsm_state_t;

  typedef enum logic [3:0] {
    DP_NONE, DP_LATCH, DP_CLR, DP_FMT_WR, DP_RD, DP_CAP, DP_ADV, DP_A_WR,
    DP_F_CLR, DP_RUN_START, DP_RUN_ADD, DP_RUN_END, DP_M_WR, DP_RES
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t res;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t opcode;
    logic    hdr_last;
    logic    aw_last;
    logic    mw_last;
    logic    clr_last;
    logic    scan_more;
    logic    fits;
    logic    too_big;
    logic    stop;
    logic    free_ok;
    logic    is_free;
    logic    in_run;
    logic    out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/phf_req_if.sv =====
`default_nettype none
interface phf_req_if
  import phf_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [AMT_W-1:0] amount;
  logic [OFS_W-1:0] offset;

  modport source (output valid, opcode, amount, offset, input ready);
  modport sink   (input valid, opcode, amount, offset, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/phf_rsp_if.sv =====
`default_nettype none
interface phf_rsp_if
  import phf_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [OFS_W-1:0] data_offset;

  modport source (output valid, status, data_offset, input ready);
  modport sink   (input valid, status, data_offset, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/phf_datapath.sv =====
`default_nettype none
module phf_datapath
  import phf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic [1:0]       req_opcode,
  input  wire logic [AMT_W-1:0] req_amount,
  input  wire logic [OFS_W-1:0] req_offset,
  input  wire logic             rsp_ready,
  output logic                  rsp_valid,
  output logic [1:0]            rsp_status,
  output logic [OFS_W-1:0]      rsp_data_offset,
  input  wire dp_cmd_t          cmd,
  output dp_stat_t              stat
);

  logic [7:0] mem [PAGE_BYTES];

  logic [CFG_W-1:0]  page_size;
  opcode_t           opcode;
  logic [AMT_W-1:0]  amount;
  logic [OFS_W-1:0]  offset;
  logic [POS_W-1:0]  pos;
  logic              is_free;
  logic [SIZE_W-1:0] size;
  logic [3:0]        k;
  logic [AW-1:0]     cnt;
  logic [AW-1:0]     run_pos;
  logic [SIZE_W-1:0] run_size;
  logic              in_run;
  logic              out_valid;
  status_t           out_status;
  logic [OFS_W-1:0]  out_data;
  logic [7:0]        rdata;

  logic [PW-1:0]     p;
  logic [POS_W-1:0]  p_w;
  logic [POS_W-1:0]  amt_w;
  logic [SIZE_W-1:0] fmt_size;
  logic [SIZE_W-1:0] rem_size;
  logic [WAW-1:0]    a_addr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [7:0]        wdata;
  logic [AW-1:0]     raddr;

  function automatic logic [7:0] byte_sel(logic [SIZE_W-1:0] w, logic [1:0] i);
    return w[8*i +: 8];
  endfunction

  always_comb begin
    if (32'(page_size) < PAGE_MIN) begin
      p = PW'(PAGE_MIN);
    end else if (32'(page_size) > PAGE_BYTES) begin
      p = PW'(PAGE_BYTES);
    end else begin
      p = PW'(page_size);
    end
  end

  assign p_w      = POS_W'(p);
  assign amt_w    = POS_W'(amount);
  assign fmt_size = SIZE_W'(p) - SIZE_W'(HEADER_BYTES);
  assign rem_size = size - SIZE_W'(HEADER_BYTES) - SIZE_W'(amount);
  // The remainder header lands directly after the new data: base + amount + k.
  assign a_addr   = WAW'(pos[AW-1:0]) + ((k >= 4'd5) ? WAW'(amount) : WAW'(0)) + WAW'(k);
  assign raddr    = pos[AW-1:0] + AW'(k);

  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = 8'd0;
    case (cmd.op)
      DP_CLR: begin
        we = 1'b1;
      end
      DP_FMT_WR: begin
        we    = 1'b1;
        waddr = AW'(k);
        wdata = (k == 4'd0) ? 8'd0 : byte_sel(fmt_size, 2'(k - 4'd1));
      end
      DP_A_WR: begin
        we    = (a_addr < WAW'(p));
        waddr = a_addr[AW-1:0];
        if (k == 4'd0) begin
          wdata = 8'd1;
        end else if (k <= 4'd4) begin
          wdata = byte_sel(SIZE_W'(amount), 2'(k - 4'd1));
        end else if (k == 4'd5) begin
          wdata = 8'd0;
        end else begin
          wdata = byte_sel(rem_size, 2'(k - 4'd6));
        end
      end
      DP_F_CLR: begin
        we    = 1'b1;
        waddr = AW'(offset - OFS_W'(HEADER_BYTES));
      end
      DP_M_WR: begin
        we    = 1'b1;
        waddr = run_pos + AW'(1) + AW'(k);
        wdata = byte_sel(run_size, k[1:0]);
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size <= CFG_W'(PAGE_SIZE_RESET);
      k         <= '0;
      cnt       <= '0;
      in_run    <= 1'b0;
      out_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (cfg_we) begin
        page_size <= cfg_wdata;
      end
      if (out_valid && rsp_ready && cmd.op != DP_RES) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        DP_LATCH: begin
          opcode <= opcode_t'(req_opcode);
          amount <= req_amount;
          offset <= req_offset;
          pos    <= '0;
          k      <= '0;
          cnt    <= '0;
          in_run <= 1'b0;
        end
        DP_CLR: cnt <= stat.clr_last ? '0 : cnt + AW'(1);
        DP_FMT_WR: k <= stat.hdr_last ? 4'd0 : k + 4'd1;
        DP_CAP: begin
          if (k == 4'd0) begin
            is_free <= (rdata == 8'd0);
          end else begin
            size[8*(k-4'd1) +: 8] <= rdata;
          end
          k <= stat.hdr_last ? 4'd0 : k + 4'd1;
        end
        DP_ADV: pos <= pos + POS_W'(HEADER_BYTES) + POS_W'(size);
        DP_A_WR: k <= stat.aw_last ? 4'd0 : k + 4'd1;
        DP_RUN_START: begin
          in_run   <= 1'b1;
          run_pos  <= pos[AW-1:0];
          run_size <= size;
        end
        DP_RUN_ADD: run_size <= run_size + size + SIZE_W'(HEADER_BYTES);
        DP_RUN_END: in_run <= 1'b0;
        DP_M_WR: k <= stat.mw_last ? 4'd0 : k + 4'd1;
        DP_RES: begin
          out_valid  <= 1'b1;
          out_status <= cmd.res;
          out_data   <= (cmd.res == ST_OK && opcode == OP_ALLOC) ?
                        OFS_W'(pos[AW-1:0] + AW'(HEADER_BYTES)) : '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.opcode    = opcode;
    stat.hdr_last  = (k == 4'd4);
    stat.aw_last   = (k == 4'd9);
    stat.mw_last   = (k == 4'd3);
    stat.clr_last  = (cnt == AW'(PAGE_BYTES - 1));
    stat.scan_more = (pos < p_w - POS_W'(HEADER_BYTES));
    stat.fits      = is_free && (POS_W'(size) > amt_w + POS_W'(HEADER_BYTES));
    stat.too_big   = (amt_w > p_w - POS_W'(2 * HEADER_BYTES));
    stat.stop      = (pos > p_w) || ((p_w - pos) < amt_w);
    stat.free_ok   = (offset >= OFS_W'(HEADER_BYTES)) &&
                     (POS_W'(offset) - POS_W'(HEADER_BYTES) < p_w);
    stat.is_free   = is_free;
    stat.in_run    = in_run;
    stat.out_free  = !out_valid || rsp_ready;
  end

  assign rsp_valid       = out_valid;
  assign rsp_status      = out_status;
  assign rsp_data_offset = out_data;

endmodule
`default_nettype wire

// ===== rtl/core/phf_ctrl.sv =====
`default_nettype none
module phf_ctrl
  import phf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  fsm_state_t state, state_next;
  status_t    res_code, res_code_next;
  logic       boot, boot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      res_code <= ST_OK;
      boot     <= 1'b1;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
      boot     <= boot_next;
    end
  end

  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    boot_next     = boot;
    req_ready     = 1'b0;
    cmd.op        = DP_NONE;
    cmd.res       = res_code;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op     = DP_LATCH;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.opcode)
          OP_FORMAT: state_next = S_CLR;
          OP_ALLOC: begin
            if (stat.too_big) begin
              res_code_next = ST_TOO_BIG;
              state_next    = S_RES;
            end else begin
              state_next = S_HRD;
            end
          end
          OP_FREE: begin
            if (stat.free_ok) begin
              state_next = S_FCLR;
            end else begin
              res_code_next = ST_BAD_OFFSET;
              state_next    = S_RES;
            end
          end
          default: begin
            res_code_next = ST_OK;
            state_next    = S_RES;
          end
        endcase
      end
      S_CLR: begin
        cmd.op = DP_CLR;
        if (stat.clr_last) begin
          state_next = S_FMT;
        end
      end
      S_FMT: begin
        cmd.op = DP_FMT_WR;
        if (stat.hdr_last) begin
          // The format after reset produces no response.
          if (boot) begin
            boot_next  = 1'b0;
            state_next = S_IDLE;
          end else begin
            res_code_next = ST_OK;
            state_next    = S_RES;
          end
        end
      end
      S_HRD: begin
        cmd.op     = DP_RD;
        state_next = S_HCAP;
      end
      S_HCAP: begin
        cmd.op     = DP_CAP;
        state_next = stat.hdr_last ? S_EVAL : S_HRD;
      end
      S_EVAL: begin
        if (stat.opcode == OP_ALLOC) begin
          state_next = stat.fits ? S_AWR : S_ADV;
        end else if (!stat.is_free) begin
          cmd.op     = DP_RUN_END;
          state_next = S_ADV;
        end else if (stat.in_run) begin
          cmd.op     = DP_RUN_ADD;
          state_next = S_MWR;
        end else begin
          cmd.op     = DP_RUN_START;
          state_next = S_ADV;
        end
      end
      S_ADV: begin
        cmd.op     = DP_ADV;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.opcode == OP_ALLOC) begin
          if (stat.stop || !stat.scan_more) begin
            res_code_next = ST_NO_FREE;
            state_next    = S_RES;
          end else begin
            state_next = S_HRD;
          end
        end else if (stat.scan_more) begin
          state_next = S_HRD;
        end else begin
          res_code_next = ST_OK;
          state_next    = S_RES;
        end
      end
      S_AWR: begin
        cmd.op = DP_A_WR;
        if (stat.aw_last) begin
          res_code_next = ST_OK;
          state_next    = S_RES;
        end
      end
      S_MWR: begin
        cmd.op = DP_M_WR;
        if (stat.mw_last) begin
          state_next = S_ADV;
        end
      end
      S_FCLR: begin
        cmd.op     = DP_F_CLR;
        state_next = S_HRD;
      end
      S_RES: begin
        if (stat.out_free) begin
          cmd.op     = DP_RES;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/page_heap_first_fit_allocator.sv =====
`default_nettype none
// Channel  Role    Payload
// req      sink    opcode, amount, offset
// rsp      source  status, data_offset
// cfg      write   cfg_wdata = page_size, taken when cfg_we is high
//
// One request is in flight at a time; the byte-wide page store sets the pace.
// Each header is read one byte at a time (5 bytes, registered read), allocate writes the
// 10 bytes of two headers, each merge rewrites 4 size bytes, and a format clears all
// PAGE_BYTES bytes and then writes the first header. After reset such a clearing pass
// formats the page before the first request is taken. The response register lets a
// request be accepted while the previous response still waits.
module page_heap_first_fit_allocator
  import phf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  phf_req_if.sink               req,
  phf_rsp_if.source             rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  phf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  phf_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .req_opcode      (req.opcode),
    .req_amount      (req.amount),
    .req_offset      (req.offset),
    .rsp_ready       (rsp.ready),
    .rsp_valid       (rsp.valid),
    .rsp_status      (rsp.status),
    .rsp_data_offset (rsp.data_offset),
    .cmd             (cmd),
    .stat            (stat)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while the previous one is still in progress");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !req.ready)
    else $error("request accepted during the clearing pass");

  a_offset_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.data_offset == '0)
    else $error("data offset given with a failed response");

endmodule
`default_nettype wire

// ===== tb/phf_tb_if.sv =====
`timescale 1ns / 1ps
// The block's own request and response interfaces are used directly; this
// file holds the small per-phase stall settings shared by the testbench.
package phf_tb_pkg;
  typedef struct {
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
  } idle_mix_t;
endpackage

// ===== tb/page_heap_first_fit_allocator_tb.sv =====
`timescale 1ns / 1ps
module page_heap_first_fit_allocator_tb;
  import phf_pkg::*;
  import phf_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES  = 4000;

  typedef struct {
    status_t          status;
    logic [OFS_W-1:0] data_offset;
  } alloc_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  phf_req_if req ();
  phf_rsp_if rsp ();

  page_heap_first_fit_allocator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .req(req), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Shadow of the page and its register.
  logic [7:0]       heap_bytes [PAGE_BYTES];
  logic [CFG_W-1:0] page_size_reg;
  alloc_reply_t     pending_replies [$];
  int               mismatches = 0;
  int               idle_cycles = 0;
  idle_mix_t        mix;
  logic [OFS_W-1:0] live_offsets [$];

  function automatic longint page_in_use();
    longint p;
    p = page_size_reg;
    if (p < PAGE_MIN) p = PAGE_MIN;
    if (p > PAGE_BYTES) p = PAGE_BYTES;
    return p;
  endfunction

  function automatic logic [7:0] rd_byte(longint pos);
    return (pos < PAGE_BYTES) ? heap_bytes[pos] : 8'd0;
  endfunction

  function automatic logic [31:0] rd_size(longint pos);
    return {rd_byte(pos + 4), rd_byte(pos + 3), rd_byte(pos + 2), rd_byte(pos + 1)};
  endfunction

  function automatic void wr_byte(longint pos, logic [7:0] v, longint lim);
    if (pos < lim && pos < PAGE_BYTES) heap_bytes[pos] = v;
  endfunction

  function automatic void wr_header(longint pos, logic [7:0] used, logic [31:0] sz,
                                    longint lim);
    wr_byte(pos, used, lim);
    for (int i = 0; i < 4; i++) wr_byte(pos + 1 + i, sz[8*i +: 8], lim);
  endfunction

  function automatic void format_heap();
    longint p;
    p = page_in_use();
    foreach (heap_bytes[i]) heap_bytes[i] = 8'd0;
    wr_header(0, 8'd0, 32'(p - HEADER_BYTES), p);
  endfunction

  function automatic void coalesce_heap();
    longint p, pos, run_pos;
    logic in_run;
    logic [31:0] run_size, sz;
    p = page_in_use();
    pos = 0;
    in_run = 1'b0;
    run_pos = 0;
    run_size = '0;
    while (pos < p - HEADER_BYTES) begin
      sz = rd_size(pos);
      if (rd_byte(pos) == 8'd0) begin
        if (!in_run) begin
          in_run = 1'b1;
          run_pos = pos;
          run_size = sz;
        end else begin
          run_size = run_size + sz + 32'(HEADER_BYTES);
          wr_header(run_pos, 8'd0, run_size, p);
        end
      end else begin
        in_run = 1'b0;
      end
      pos = pos + HEADER_BYTES + longint'(sz);
    end
  endfunction

  function automatic alloc_reply_t predict_heap_op(opcode_t op, logic [AMT_W-1:0] amt,
                                                   logic [OFS_W-1:0] ofs);
    alloc_reply_t r;
    longint p, pos, a;
    logic [31:0] sz;
    logic done;
    r.status = ST_OK;
    r.data_offset = '0;
    p = page_in_use();
    a = amt;
    case (op)
      OP_FORMAT: format_heap();
      OP_ALLOC: begin
        if (a > p - 2 * HEADER_BYTES) begin
          r.status = ST_TOO_BIG;
        end else begin
          r.status = ST_NO_FREE;
          pos = 0;
          done = 1'b0;
          while (!done && pos < p - HEADER_BYTES) begin
            sz = rd_size(pos);
            if (rd_byte(pos) == 8'd0 && longint'(sz) > a + HEADER_BYTES) begin
              wr_header(pos, 8'd1, 32'(a), p);
              wr_header(pos + HEADER_BYTES + a, 8'd0, 32'(longint'(sz) - HEADER_BYTES - a), p);
              r.status = ST_OK;
              r.data_offset = OFS_W'(pos + HEADER_BYTES);
              done = 1'b1;
            end else begin
              pos = pos + HEADER_BYTES + longint'(sz);
              if (pos > p || p - pos < a) done = 1'b1;
            end
          end
        end
      end
      OP_FREE: begin
        if (ofs < HEADER_BYTES || longint'(ofs) - HEADER_BYTES >= p) begin
          r.status = ST_BAD_OFFSET;
        end else begin
          wr_byte(longint'(ofs) - HEADER_BYTES, 8'd0, p);
          coalesce_heap();
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(opcode_t op, logic [AMT_W-1:0] amt, logic [OFS_W-1:0] ofs);
    alloc_reply_t r;
    // The previous request drops valid at a falling edge, so start at the next one.
    do @(negedge clk); while ($urandom_range(99) < mix.send_idle_pct);
    req.valid <= 1'b1;
    req.opcode <= op;
    req.amount <= amt;
    req.offset <= ofs;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    r = predict_heap_op(op, amt, ofs);
    pending_replies.push_back(r);
    if (op == OP_ALLOC && r.status == ST_OK) live_offsets.push_back(r.data_offset);
    if (op == OP_FORMAT) live_offsets.delete();
    @(negedge clk);
    req.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_page_size(logic [CFG_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    page_size_reg = v;
  endtask

  // Response checker.
  always @(posedge clk) begin
    alloc_reply_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response status=%0d", rsp.status);
      end else begin
        want = pending_replies.pop_front();
        if (rsp.status !== want.status || rsp.data_offset !== want.data_offset) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status=%0d ofs=%0d, got status=%0d ofs=%0d",
                     want.status, want.data_offset, rsp.status, rsp.data_offset);
        end
      end
    end
  end

  always @(negedge clk) rsp.ready <= ($urandom_range(99) >= mix.recv_stall_pct);

  // A stall counts only cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic random_mix_item();
    int k;
    k = $urandom_range(99);
    if (k < 45) begin
      send_request(OP_ALLOC, AMT_W'($urandom_range(32'(page_in_use() / 4))), '0);
    end else if (k < 80 && live_offsets.size() != 0) begin
      int j;
      j = $urandom_range(live_offsets.size() - 1);
      send_request(OP_FREE, '0, live_offsets[j]);
      live_offsets.delete(j);
    end else if (k < 90) begin
      send_request(opcode_t'($urandom_range(3)), AMT_W'($urandom), OFS_W'($urandom));
    end else if (k < 93) begin
      send_request(OP_FORMAT, '0, '0);
    end else begin
      send_request(OP_FREE, AMT_W'($urandom), OFS_W'($urandom));
    end
  endtask

  task automatic test_directed();
    send_request(OP_ALLOC, 10'd502, '0);
    send_request(OP_ALLOC, 10'd1023, '0);
    send_request(OP_ALLOC, 10'd0, '0);
    send_request(OP_ALLOC, 10'd100, '0);
    send_request(OP_ALLOC, 10'd400, '0);
    send_request(OP_FREE, '0, 9'd4);
    send_request(OP_FREE, '0, 9'd0);
    send_request(OP_FREE, '0, 9'd5);
    send_request(OP_FREE, '0, 9'd10);
    send_request(OP_FREE, '0, 9'd7);
    send_request(OP_FREE, '0, 9'd511);
    send_request(OP_NOP, 10'h3ff, 9'h1ff);
    send_request(OP_ALLOC, 10'd490, '0);
    send_request(OP_FORMAT, '0, '0);
    send_request(OP_ALLOC, 10'd497, '0);
    send_request(OP_ALLOC, 10'd20, '0);
  endtask

  task automatic test_page_sizes();
    set_page_size(10'd16);
    send_request(OP_ALLOC, 10'd6, '0);
    send_request(OP_ALLOC, 10'd0, '0);
    send_request(OP_FREE, '0, 9'd21);
    send_request(OP_FORMAT, '0, '0);
    send_request(OP_ALLOC, 10'd0, '0);
    send_request(OP_ALLOC, 10'd1, '0);
    set_page_size(10'd0);
    send_request(OP_ALLOC, 10'd3, '0);
    set_page_size(10'h3ff);
    send_request(OP_ALLOC, 10'd200, '0);
    send_request(OP_FREE, '0, 9'd5);
  endtask

  task automatic test_random_phases();
    idle_mix_t phases [4];
    int sizes [4];
    phases[0] = '{0, 0};
    phases[1] = '{69, 0};
    phases[2] = '{0, 69};
    phases[3] = '{6, 6};
    sizes = '{512, 64, 200, 16};
    foreach (phases[ph]) begin
      mix = phases[ph];
      set_page_size(CFG_W'(sizes[ph]));
      send_request(OP_FORMAT, '0, '0);
      repeat (140) random_mix_item();
    end
  endtask

  initial begin
    mix = '{0, 0};
    req.valid = 1'b0;
    req.opcode = '0;
    req.amount = '0;
    req.offset = '0;
    rsp.ready = 1'b0;
    page_size_reg = CFG_W'(PAGE_SIZE_RESET);
    format_heap();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_page_sizes();
    test_random_phases();
    drain();
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
